/* rtl/oile_pkg.sv */
`default_nettype none

package oile_pkg;

   // Field widths of the stream payloads.
   localparam int MODE_W  = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 7;
   localparam int CNT_W   = 7;
   localparam int STAT_W  = 2;

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DISPLAY   = 3'd5;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

   // Sequencer states, one-hot.
   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_INS_RD  = 11'b000_0000_0010,
      S_INS_WR  = 11'b000_0000_0100,
      S_INS_PUT = 11'b000_0000_1000,
      S_DEL_RD  = 11'b000_0001_0000,
      S_DEL_CMP = 11'b000_0010_0000,
      S_DEL_SRD = 11'b000_0100_0000,
      S_DEL_SWR = 11'b000_1000_0000,
      S_DSP_RD  = 11'b001_0000_0000,
      S_DSP_OUT = 11'b010_0000_0000,
      S_RESP    = 11'b100_0000_0000
   } state_type;

endpackage

`default_nettype wire

/* rtl/ordered_integer_list_engine.sv */
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit integers held in a single-port-write,
// registered-read RAM and worked by a small sequencer that moves one entry at a
// time. Each request takes one transfer on the req_ channel; the block is not
// ready until the request has been fully handled. Insert at front or at a position
// shifts every entry behind the insertion point up by one, reading each entry and
// then writing it one place higher, before the new value is written and the
// response is loaded; a back insert moves nothing. A delete scans from the front,
// reading and comparing one entry at a time, then closes the gap by reading and
// writing each entry behind the match one place lower. Clear, unused modes and
// refused inserts go straight to the response. Display issues one response per
// entry, reading each entry first, and a stalled rsp_ side holds the walk back;
// an empty list answers with one status-only response. Every request but display
// gives exactly one response, and rsp_tlast marks the final response of each
// request. The response register lets the next request be accepted while the last
// response still waits. The list storage needs no clearing after reset.
module ordered_integer_list_engine #(
   parameter int DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // mode[2:0], value[34:3], position[41:35], zero pad
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // entry_value[31:0], entry_position[38:32],
                                        // entry_count[45:39], zero pad
   output logic [1:0]       rsp_tuser,  // status[1:0]
   output logic             rsp_tlast   // last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = oile_pkg::CNT_W;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   // Request fields.
   logic [oile_pkg::MODE_W-1:0]  req_mode;
   logic [oile_pkg::VALUE_W-1:0] req_value;
   logic [oile_pkg::POS_W-1:0]   req_position;

   assign req_mode     = req_tdata[2:0];
   assign req_value    = req_tdata[34:3];
   assign req_position = req_tdata[41:35];

   // Sequencer and operand registers.
   oile_pkg::state_type          state_ff, state_in;
   logic [CW-1:0]                len_ff, len_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                tgt_ff, tgt_in;
   logic [oile_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [oile_pkg::STAT_W-1:0]  stat_ff, stat_in;

   // Response register.
   logic                         out_valid_ff, out_valid_in;
   logic [oile_pkg::STAT_W-1:0]  out_stat_ff, out_stat_in;
   logic [oile_pkg::VALUE_W-1:0] out_val_ff, out_val_in;
   logic [CW-1:0]                out_pos_ff, out_pos_in;
   logic [CW-1:0]                out_cnt_ff, out_cnt_in;
   logic                         out_last_ff, out_last_in;

   // RAM ports.
   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [oile_pkg::VALUE_W-1:0] ram_wr_data;
   logic                         ram_rd_en;
   logic [AW-1:0]                ram_rd_addr;
   logic [oile_pkg::VALUE_W-1:0] ram_rd_data;

   logic                         out_free;
   logic                         req_xfer;
   logic [CW-1:0]                idx_dec;
   logic [CW-1:0]                idx_inc;
   logic [CW-1:0]                idx_inc2;
   logic [CW-1:0]                len_inc;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == oile_pkg::S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign idx_dec    = idx_ff - CW'(1);
   assign idx_inc    = idx_ff + CW'(1);
   assign idx_inc2   = idx_ff + CW'(2);
   assign len_inc    = len_ff + CW'(1);

   oile_ram #(
      .WIDTH (oile_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer next-state logic, RAM control and response loading.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      tgt_in       = tgt_ff;
      val_in       = val_ff;
      stat_in      = stat_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_stat_in  = out_stat_ff;
      out_val_in   = out_val_ff;
      out_pos_in   = out_pos_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff[AW-1:0];
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff[AW-1:0];

      unique case (state_ff)
         oile_pkg::S_IDLE: begin
            if (req_xfer) begin
               val_in  = req_value;
               stat_in = oile_pkg::ST_DONE;
               idx_in  = len_ff;
               state_in = oile_pkg::S_RESP;
               if (req_mode == oile_pkg::MODE_INS_FRONT ||
                   req_mode == oile_pkg::MODE_INS_BACK ||
                   req_mode == oile_pkg::MODE_INS_POS) begin
                  // Pick the insertion index, then shift the tail up.
                  if (len_ff == DEPTH_CNT) begin
                     stat_in = oile_pkg::ST_FULL;
                  end else begin
                     priority if (req_mode == oile_pkg::MODE_INS_FRONT) begin
                        tgt_in = '0;
                     end else if (req_mode == oile_pkg::MODE_INS_BACK || len_ff == '0) begin
                        tgt_in = len_ff;
                     end else if (req_position >= CW'(1) && req_position <= len_inc) begin
                        tgt_in = req_position - CW'(1);
                     end else begin
                        tgt_in = len_ff;
                     end
                     state_in = (len_ff > tgt_in) ? oile_pkg::S_INS_RD
                                                  : oile_pkg::S_INS_PUT;
                  end
               end else if (req_mode == oile_pkg::MODE_DELETE) begin
                  if (len_ff == '0) begin
                     stat_in = oile_pkg::ST_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = oile_pkg::S_DEL_RD;
                  end
               end else if (req_mode == oile_pkg::MODE_CLEAR) begin
                  len_in = '0;
               end else if (req_mode == oile_pkg::MODE_DISPLAY) begin
                  if (len_ff == '0) begin
                     stat_in = oile_pkg::ST_EMPTY;
                     val_in  = '0;
                  end else begin
                     idx_in   = '0;
                     state_in = oile_pkg::S_DSP_RD;
                  end
               end
            end
         end

         // Shift up: read entry idx-1, then write it to idx.
         oile_pkg::S_INS_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_dec[AW-1:0];
            state_in    = oile_pkg::S_INS_WR;
         end

         oile_pkg::S_INS_WR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_dec;
            state_in  = (idx_dec > tgt_ff) ? oile_pkg::S_INS_RD : oile_pkg::S_INS_PUT;
         end

         oile_pkg::S_INS_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = tgt_ff[AW-1:0];
            ram_wr_data = val_ff;
            len_in      = len_inc;
            state_in    = oile_pkg::S_RESP;
         end

         // Linear search for the first matching entry.
         oile_pkg::S_DEL_RD: begin
            ram_rd_en = 1'b1;
            state_in  = oile_pkg::S_DEL_CMP;
         end

         oile_pkg::S_DEL_CMP: begin
            if (ram_rd_data == val_ff) begin
               if (idx_inc < len_ff) begin
                  state_in = oile_pkg::S_DEL_SRD;
               end else begin
                  len_in   = len_ff - CW'(1);
                  state_in = oile_pkg::S_RESP;
               end
            end else if (idx_inc == len_ff) begin
               stat_in  = oile_pkg::ST_NOTFOUND;
               state_in = oile_pkg::S_RESP;
            end else begin
               idx_in   = idx_inc;
               state_in = oile_pkg::S_DEL_RD;
            end
         end

         // Close the gap: read entry idx+1, then write it to idx.
         oile_pkg::S_DEL_SRD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_inc[AW-1:0];
            state_in    = oile_pkg::S_DEL_SWR;
         end

         oile_pkg::S_DEL_SWR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_inc;
            if (idx_inc2 < len_ff) begin
               state_in = oile_pkg::S_DEL_SRD;
            end else begin
               len_in   = len_ff - CW'(1);
               state_in = oile_pkg::S_RESP;
            end
         end

         // Display walk: one response per entry.
         oile_pkg::S_DSP_RD: begin
            ram_rd_en = 1'b1;
            state_in  = oile_pkg::S_DSP_OUT;
         end

         oile_pkg::S_DSP_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_stat_in  = oile_pkg::ST_DONE;
               out_val_in   = ram_rd_data;
               out_pos_in   = idx_inc;
               out_cnt_in   = len_ff;
               out_last_in  = (idx_inc == len_ff);
               idx_in       = idx_inc;
               state_in     = (idx_inc == len_ff) ? oile_pkg::S_IDLE : oile_pkg::S_DSP_RD;
            end
         end

         // Single response for every other operation.
         oile_pkg::S_RESP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_stat_in  = stat_ff;
               out_val_in   = val_ff;
               out_pos_in   = '0;
               out_cnt_in   = len_ff;
               out_last_in  = 1'b1;
               state_in     = oile_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = oile_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oile_pkg::S_IDLE;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Operand and response payload registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      tgt_ff      <= tgt_in;
      val_ff      <= val_in;
      stat_ff     <= stat_in;
      out_stat_ff <= out_stat_in;
      out_val_ff  <= out_val_in;
      out_pos_ff  <= out_pos_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_cnt_ff, out_pos_ff, out_val_ff};
   assign rsp_tuser  = out_stat_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

/* rtl/oile_ram.sv */
`default_nettype none

module oile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* bench/oile_list_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the list engine, keeps its own copy of the list and
// compares every response transfer with the oldest expected one.
module oile_list_checker #(
   parameter int DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,  // mode[2:0], value[34:3], position[41:35], zero pad
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,  // entry_value[31:0], entry_position[38:32],
                                        // entry_count[45:39], zero pad
   input  wire logic [1:0]  rsp_tuser,  // status[1:0]
   input  wire logic        rsp_tlast,
   output int               error_count,
   output int               pending_results
);

   typedef struct packed {
      logic [oile_pkg::STAT_W-1:0]  status;
      logic [oile_pkg::VALUE_W-1:0] entry_value;
      logic [oile_pkg::POS_W-1:0]   entry_position;
      logic [oile_pkg::CNT_W-1:0]   entry_count;
      logic                         last;
   } list_result_type;

   // Expected contents of the list, front first.
   logic [oile_pkg::VALUE_W-1:0] shadow_list[$];
   list_result_type              expected_results[$];
   int                           mismatch_total = 0;

   // One line per mismatch, and the count goes up.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_total++;
      $display("[%0t] response %s mismatch: got %0h, expected %0h", $time, what, got, want);
   endtask

   function automatic list_result_type make_result(input logic [oile_pkg::STAT_W-1:0] status,
                                                   input logic [oile_pkg::VALUE_W-1:0] value,
                                                   input int position, input int count,
                                                   input logic last);
      list_result_type r;
      r.status         = status;
      r.entry_value    = value;
      r.entry_position = position[oile_pkg::POS_W-1:0];
      r.entry_count    = count[oile_pkg::CNT_W-1:0];
      r.last           = last;
      return r;
   endfunction

   // Applies one request to the shadow list and queues the responses it causes.
   task automatic predict_request(input logic [oile_pkg::MODE_W-1:0] mode,
                                  input logic [oile_pkg::VALUE_W-1:0] value,
                                  input logic [oile_pkg::POS_W-1:0] position);
      logic [oile_pkg::STAT_W-1:0] status;
      int                          length;
      int                          found;
      status = oile_pkg::ST_DONE;
      length = shadow_list.size();
      found  = -1;
      if (mode == oile_pkg::MODE_DISPLAY) begin
         // An empty list answers with a single status-only response.
         if (length == 0) begin
            expected_results.push_back(make_result(oile_pkg::ST_EMPTY, '0, 0, 0, 1'b1));
         end else begin
            for (int i = 0; i < length; i++) begin
               expected_results.push_back(make_result(oile_pkg::ST_DONE, shadow_list[i],
                                                      i + 1, length, i == length - 1));
            end
         end
      end else begin
         case (mode)
            oile_pkg::MODE_INS_FRONT, oile_pkg::MODE_INS_BACK, oile_pkg::MODE_INS_POS: begin
               // A position outside 1 to count+1 appends at the end.
               if (length >= DEPTH)
                  status = oile_pkg::ST_FULL;
               else if (mode == oile_pkg::MODE_INS_FRONT)
                  shadow_list.push_front(value);
               else if (mode == oile_pkg::MODE_INS_BACK || length == 0)
                  shadow_list.push_back(value);
               else if (position >= 1 && int'(position) <= length + 1)
                  shadow_list.insert(int'(position) - 1, value);
               else
                  shadow_list.push_back(value);
            end
            oile_pkg::MODE_DELETE: begin
               if (length == 0) begin
                  status = oile_pkg::ST_EMPTY;
               end else begin
                  for (int i = 0; i < length; i++) begin
                     if (found < 0 && shadow_list[i] == value) found = i;
                  end
                  if (found < 0)
                     status = oile_pkg::ST_NOTFOUND;
                  else
                     shadow_list.delete(found);
               end
            end
            oile_pkg::MODE_CLEAR: shadow_list.delete();
            default: ;
         endcase
         expected_results.push_back(make_result(status, value, 0, shadow_list.size(), 1'b1));
      end
   endtask

   // Compares one response transfer with the oldest expectation, field by field.
   task automatic check_response();
      list_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("with nothing expected, value", rsp_tdata[31:0], '0);
      end else begin
         want = expected_results.pop_front();
         if (rsp_tuser != want.status)
            report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
         if (rsp_tdata[31:0] != want.entry_value)
            report_mismatch("entry_value", rsp_tdata[31:0], want.entry_value);
         if (rsp_tdata[38:32] != want.entry_position)
            report_mismatch("entry_position", 32'(rsp_tdata[38:32]), 32'(want.entry_position));
         if (rsp_tdata[45:39] != want.entry_count)
            report_mismatch("entry_count", 32'(rsp_tdata[45:39]), 32'(want.entry_count));
         if (rsp_tlast != want.last)
            report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
      end
   endtask

   // Responses are checked before the request of the same edge is predicted,
   // since a response can never belong to a request accepted at that edge.
   always @(posedge clock) begin
      if (reset) begin
         shadow_list.delete();
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready) begin
            predict_request(req_tdata[2:0], req_tdata[34:3], req_tdata[41:35]);
         end
      end
      error_count     <= mismatch_total;
      pending_results <= expected_results.size();
   end

endmodule

/* bench/ordered_integer_list_engine_tb.sv */
`timescale 1ns / 1ps

module ordered_integer_list_engine_tb;

   localparam int LIST_DEPTH       = 64;
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int LONG_HOLD_CYCLES = 300;
   // Mode codes that the block must answer without touching the list.
   localparam logic [oile_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
   localparam logic [oile_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;  // mode[2:0], value[34:3], position[41:35], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // entry_value[31:0], entry_position[38:32],
                                  // entry_count[45:39], zero pad
   logic [1:0]  rsp_tuser;        // status[1:0]
   logic        rsp_tlast;

   int mismatch_count;
   int pending_count;
   int cycle_count       = 0;
   int long_hold_request = 0;
   bit sender_idle_on    = 1'b0;
   bit receiver_stall_on = 1'b0;

   always #2 clock = ~clock;

   ordered_integer_list_engine #(
      .DEPTH(LIST_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   oile_list_checker #(
      .DEPTH(LIST_DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .error_count     (mismatch_count),
      .pending_results (pending_count)
   );

   // Offers one request, after an optional idle burst, and waits for its transfer.
   task automatic send_request(input logic [oile_pkg::MODE_W-1:0] mode,
                               input logic [oile_pkg::VALUE_W-1:0] value,
                               input logic [oile_pkg::POS_W-1:0] position);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, position, value, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Mostly small values so that deletes find their target; the rest full range.
   function automatic logic [oile_pkg::VALUE_W-1:0] random_value();
      logic [oile_pkg::VALUE_W-1:0] small_value;
      small_value = $urandom_range(0, 15);
      case ($urandom_range(0, 3))
         0, 1: return small_value - 32'd8;
         2: return $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // Positions 0 to 12 most of the time, any 7-bit value otherwise.
   function automatic logic [oile_pkg::POS_W-1:0] random_position();
      logic [oile_pkg::POS_W-1:0] position;
      if ($urandom_range(0, 3) == 0)
         position = oile_pkg::POS_W'($urandom_range(0, 127));
      else
         position = oile_pkg::POS_W'($urandom_range(0, 12));
      return position;
   endfunction

   task automatic send_random_request();
      int                          pick;
      logic [oile_pkg::MODE_W-1:0] mode;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         mode = oile_pkg::MODE_INS_FRONT;
      else if (pick < 40)
         mode = oile_pkg::MODE_INS_BACK;
      else if (pick < 60)
         mode = oile_pkg::MODE_INS_POS;
      else if (pick < 78)
         mode = oile_pkg::MODE_DELETE;
      else if (pick < 88)
         mode = oile_pkg::MODE_DISPLAY;
      else if (pick < 93)
         mode = oile_pkg::MODE_CLEAR;
      else if (pick < 96)
         mode = MODE_UNUSED_LO;
      else
         mode = MODE_UNUSED_HI;
      send_request(mode, random_value(), random_position());
   endtask

   // Response side: random stall bursts, plus one long hold-off on request.
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         if (long_hold_request > 0) begin
            hold = long_hold_request;
            long_hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (receiver_stall_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [oile_pkg::MODE_W-1:0] fill_mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      sender_idle_on    = 1'b1;
      receiver_stall_on = 1'b1;

      // Empty-list cases, then every insert flavor and the value extremes.
      send_request(oile_pkg::MODE_DISPLAY, 32'h0000_0000, 7'd0);
      send_request(oile_pkg::MODE_DELETE, 32'h0000_0005, 7'd0);
      send_request(oile_pkg::MODE_INS_POS, 32'h0000_0007, 7'd50);
      send_request(oile_pkg::MODE_INS_FRONT, 32'h8000_0000, 7'd0);
      send_request(oile_pkg::MODE_INS_BACK, 32'h7FFF_FFFF, 7'd0);
      send_request(oile_pkg::MODE_INS_POS, 32'hFFFF_FFFF, 7'd0);
      send_request(oile_pkg::MODE_INS_POS, 32'h0000_0064, 7'd2);
      send_request(oile_pkg::MODE_INS_POS, 32'h0000_00C8, 7'd6);
      send_request(oile_pkg::MODE_INS_POS, 32'h0000_012C, 7'd1);
      send_request(oile_pkg::MODE_INS_POS, 32'h0000_0190, 7'd127);
      send_request(oile_pkg::MODE_INS_POS, 32'h0000_0000, 7'd9);
      send_request(oile_pkg::MODE_INS_POS, 32'h0000_01F4, 7'd11);
      send_request(MODE_UNUSED_LO, 32'h5A5A_5A5A, 7'h55);
      send_request(MODE_UNUSED_HI, 32'hA5A5_A5A5, 7'h2A);
      // Deletes that hit entries inside the list, then a miss.
      send_request(oile_pkg::MODE_DELETE, 32'h0000_0007, 7'd0);
      send_request(oile_pkg::MODE_DELETE, 32'h8000_0000, 7'd0);
      send_request(oile_pkg::MODE_DELETE, 32'hFFFF_FFFF, 7'd0);
      send_request(oile_pkg::MODE_DELETE, 32'h0000_3039, 7'd0);
      send_request(oile_pkg::MODE_DISPLAY, 32'h0000_0000, 7'd0);
      send_request(oile_pkg::MODE_CLEAR, 32'h1234_5678, 7'd0);
      send_request(oile_pkg::MODE_DISPLAY, 32'h0000_0000, 7'd0);
      send_request(oile_pkg::MODE_DELETE, 32'h0000_0000, 7'd0);
      send_request(oile_pkg::MODE_INS_BACK, 32'h0000_0000, 7'd0);

      repeat (45) send_random_request();

      // Fill the list to the top, then have each insert flavor refused.
      send_request(oile_pkg::MODE_CLEAR, random_value(), random_position());
      repeat (LIST_DEPTH) begin
         case ($urandom_range(0, 2))
            0: fill_mode = oile_pkg::MODE_INS_FRONT;
            1: fill_mode = oile_pkg::MODE_INS_BACK;
            default: fill_mode = oile_pkg::MODE_INS_POS;
         endcase
         send_request(fill_mode, random_value(), random_position());
      end
      send_request(oile_pkg::MODE_INS_FRONT, random_value(), random_position());
      send_request(oile_pkg::MODE_INS_BACK, random_value(), random_position());
      send_request(oile_pkg::MODE_INS_POS, random_value(), random_position());

      // Hold the response side off while a full display and deletes queue up.
      long_hold_request = LONG_HOLD_CYCLES;
      send_request(oile_pkg::MODE_DISPLAY, random_value(), random_position());
      repeat (6) send_request(oile_pkg::MODE_DELETE, random_value(), random_position());

      // Closing stretch without any idling.
      sender_idle_on    = 1'b0;
      receiver_stall_on = 1'b0;
      repeat (30) send_random_request();
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (2 * LIST_DEPTH + 10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

/* sim.f */
rtl/oile_pkg.sv
rtl/oile_ram.sv
rtl/ordered_integer_list_engine.sv
bench/oile_list_checker.sv
bench/ordered_integer_list_engine_tb.sv
